// ===== rtl/sgcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcr_pkg: shared types and constants of the glyph cell rasterizer
// Item layout between front end and back end, register indexes, reset values
// and the 5x7 font table.
// ----------------------------------------------------------------------------
package sgcr_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 8;
  localparam int GLYPH_BITS    = GLYPH_COLUMNS * GLYPH_ROWS;
  localparam int GLYPH_COUNT   = 96;
  localparam int GLYPH_IDX_W   = $clog2(GLYPH_COUNT);
  localparam int COL_W         = $clog2(GLYPH_COLUMNS + 1);
  localparam int ROW_W         = $clog2(GLYPH_ROWS);

  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0]  FIRST_CODE = 8'd32;
  localparam logic [7:0]  LAST_CODE  = 8'd127;
  localparam logic [7:0]  SUBST_CODE = 8'd63;

  localparam logic [9:0]  WIDTH_RESET  = 10'd480;
  localparam logic [9:0]  HEIGHT_RESET = 10'd320;
  localparam logic [11:0] COORD_MAX    = 12'h7FF;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  // classified character as held in the queue
  typedef struct packed {
    logic [GLYPH_BITS-1:0] glyph;   // column c in bits [8c+7:8c], bit 0 = top row
    logic signed [11:0]    origin_x;
    logic signed [11:0]    origin_y;
    logic [15:0]           fore_color;
    logic [15:0]           back_color;
    logic [3:0]            scale;
    logic                  pix_mode;
  } item_t;

  // one entry per printable code, five column bytes, column 0 lowest
  localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
    40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
    40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h325141413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
    40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
    40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3C54541408,
    40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h4428107F00,
    40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
    40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
    40'h00007F0000, 40'h0008364100, 40'h081C2A0808, 40'h08082A1C08
  };

  function automatic logic [GLYPH_BITS-1:0] glyph_lookup(logic [GLYPH_IDX_W-1:0] idx);
    logic [GLYPH_BITS-1:0] cols;
    cols = '0;
    if (int'(idx) < GLYPH_COUNT) begin
      cols = GLYPH_ROM[idx];
    end
    return cols;
  endfunction

endpackage

// ===== rtl/scaled_glyph_cell_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_glyph_cell_rasterizer: 5x7 character to rectangle stream
// Front end classifier, item queue and cell sequencer with clipping.
// ----------------------------------------------------------------------------
// Each accepted character produces one rectangle per cycle unless out_tready
// stalls: 48 one-pixel cells in single-pixel mode (scale 0 or 1) and 41
// cells at larger scales (40 glyph cells plus one spacing bar).
// Cells come column by column, top row first; out_tlast marks the final one
// and out_tuser is the visible flag. The queue holds QUEUE_DEPTH characters
// counting the one being drawn, so QUEUE_DEPTH - 1 are taken ahead of it.
// Write the screen size only while idle.
module scaled_glyph_cell_rasterizer #(
  parameter int QUEUE_DEPTH = sgcr_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // char_code[7:0], origin_x[19:8], origin_y[31:20], fore_color[47:32],
  // back_color[63:48], scale[67:64], zero pad [71:68]
  input  logic [sgcr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cell_x[11:0], cell_y[23:12], cell_w[30:24], cell_h[37:31],
  // cell_color[53:38], zero pad [55:54]
  output logic [sgcr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // visible[0]
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [9:0]                         cfg_data
);

  logic [9:0]       screen_width_r;
  logic [9:0]       screen_height_r;
  logic             push_valid;
  logic             push_ready;
  sgcr_pkg::item_t  push_item;
  logic             head_valid;
  logic             head_pop;
  sgcr_pkg::item_t  head_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= sgcr_pkg::WIDTH_RESET;
      screen_height_r <= sgcr_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sgcr_pkg::cfg_reg_t'(cfg_index))
        sgcr_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        sgcr_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sgcr_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sgcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_item  (head_item)
  );

  sgcr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .head_pop      (head_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast)
  );

endmodule

// ===== rtl/sgcr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcr_front: character classifier
// Unpacks an input transfer, substitutes unprintable codes, normalizes the
// scale, fetches the glyph columns and hands the item to the queue.
// ----------------------------------------------------------------------------
module sgcr_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sgcr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               push_valid,
  input  logic                               push_ready,
  output sgcr_pkg::item_t                    push_item
);

  logic [7:0]                        char_code;
  logic [7:0]                        code_eff;
  logic [sgcr_pkg::GLYPH_IDX_W-1:0]  glyph_idx;
  logic [3:0]                        scale_in;
  logic [3:0]                        scale_eff;

  assign char_code = in_tdata[7:0];
  assign scale_in  = in_tdata[67:64];

  always_comb begin
    if (char_code < sgcr_pkg::FIRST_CODE || char_code > sgcr_pkg::LAST_CODE) begin
      code_eff = sgcr_pkg::SUBST_CODE;
    end else begin
      code_eff = char_code;
    end
  end

  assign glyph_idx = sgcr_pkg::GLYPH_IDX_W'(code_eff - sgcr_pkg::FIRST_CODE);
  // scale zero behaves as single-pixel mode
  assign scale_eff = (scale_in == 4'd0) ? 4'd1 : scale_in;

  always_comb begin
    push_item.glyph      = sgcr_pkg::glyph_lookup(glyph_idx);
    push_item.origin_x   = $signed(in_tdata[19:8]);
    push_item.origin_y   = $signed(in_tdata[31:20]);
    push_item.fore_color = in_tdata[47:32];
    push_item.back_color = in_tdata[63:48];
    push_item.scale      = scale_eff;
    push_item.pix_mode   = (scale_eff == 4'd1);
  end

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

// ===== rtl/sgcr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcr_queue: item queue between front end and back end
// Small FIFO of classified characters; the head stays until its last cell.
// ----------------------------------------------------------------------------
module sgcr_queue #(
  parameter int DEPTH = sgcr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sgcr_pkg::item_t push_item,
  output logic            head_valid,
  input  logic            head_pop,
  output sgcr_pkg::item_t head_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sgcr_pkg::item_t    slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

// ===== rtl/sgcr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcr_back: cell sequencer and clipper
// Walks the queue head's glyph column by column, clips each cell against
// the screen and registers one rectangle per cycle unless out_tready stalls.
// ----------------------------------------------------------------------------
module sgcr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [9:0]                        screen_width,
  input  logic [9:0]                        screen_height,
  input  logic                              head_valid,
  input  sgcr_pkg::item_t                   head_item,
  output logic                              head_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sgcr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int COL_W = sgcr_pkg::COL_W;
  localparam int ROW_W = sgcr_pkg::ROW_W;
  localparam int CELL_IDX_W = COL_W + ROW_W;
  localparam int PAD_BITS = (1 << CELL_IDX_W) - sgcr_pkg::GLYPH_BITS;

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [6:0]          xoff_r, xoff_nxt;
  logic [6:0]          yoff_r, yoff_nxt;

  logic                load;
  logic                spacing_col;
  logic                last_c;
  logic                bit_set;
  logic [(1 << CELL_IDX_W)-1:0] glyph_ext;
  logic [15:0]         color_c;
  logic [6:0]          w_c, h_c;
  logic signed [12:0]  x_c, y_c;
  logic signed [12:0]  sw_c, sh_c;
  logic signed [13:0]  dx_c, dy_c;
  logic                vis_c;
  logic [6:0]          w_out, h_out;
  logic [11:0]         x_out, y_out;

  logic                out_tvalid_r;
  logic [sgcr_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                out_tuser_r;
  logic                out_tlast_r;

  assign load        = head_valid && (!out_tvalid_r || out_tready);
  assign spacing_col = (col_r == COL_W'(sgcr_pkg::GLYPH_COLUMNS));
  assign last_c      = spacing_col && (row_r == ROW_W'(sgcr_pkg::GLYPH_ROWS - 1)
                                       || !head_item.pix_mode);
  assign head_pop    = load && last_c;

  // spacing column reads the zero padding and so takes the background
  assign glyph_ext = {{PAD_BITS{1'b0}}, head_item.glyph};
  assign bit_set   = glyph_ext[{col_r, row_r}];
  assign color_c   = bit_set ? head_item.fore_color : head_item.back_color;

  assign w_c = {3'b000, head_item.scale};
  assign h_c = (spacing_col && !head_item.pix_mode) ? {head_item.scale, 3'b000}
                                                    : {3'b000, head_item.scale};

  assign x_c  = $signed({head_item.origin_x[11], head_item.origin_x})
              + $signed({6'b000000, xoff_r});
  assign y_c  = $signed({head_item.origin_y[11], head_item.origin_y})
              + $signed({6'b000000, yoff_r});
  assign sw_c = $signed({3'b000, screen_width});
  assign sh_c = $signed({3'b000, screen_height});
  assign dx_c = $signed({4'b0000, screen_width}) - $signed({x_c[12], x_c});
  assign dy_c = $signed({4'b0000, screen_height}) - $signed({y_c[12], y_c});

  always_comb begin
    if (head_item.pix_mode) begin
      vis_c = !x_c[12] && (x_c < sw_c) && !y_c[12] && (y_c < sh_c);
    end else begin
      vis_c = (x_c < sw_c) && (y_c < sh_c);
    end
  end

  // right and bottom clip; low seven bits of the remaining span
  always_comb begin
    w_out = '0;
    h_out = '0;
    if (vis_c) begin
      w_out = (dx_c < $signed({7'b0000000, w_c})) ? dx_c[6:0] : w_c;
      h_out = (dy_c < $signed({7'b0000000, h_c})) ? dy_c[6:0] : h_c;
    end
  end

  // positive overflow past the 12-bit range saturates
  assign x_out = (!x_c[12] && x_c[11]) ? sgcr_pkg::COORD_MAX : x_c[11:0];
  assign y_out = (!y_c[12] && y_c[11]) ? sgcr_pkg::COORD_MAX : y_c[11:0];

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    xoff_nxt = xoff_r;
    yoff_nxt = yoff_r;
    if (load) begin
      if (last_c) begin
        col_nxt  = '0;
        row_nxt  = '0;
        xoff_nxt = '0;
        yoff_nxt = '0;
      end else if (row_r == ROW_W'(sgcr_pkg::GLYPH_ROWS - 1)) begin
        col_nxt  = col_r + 1'b1;
        row_nxt  = '0;
        xoff_nxt = xoff_r + w_c;
        yoff_nxt = '0;
      end else begin
        row_nxt  = row_r + 1'b1;
        yoff_nxt = yoff_r + w_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      xoff_r       <= '0;
      yoff_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      xoff_r <= xoff_nxt;
      yoff_r <= yoff_nxt;
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {2'b00, color_c, h_out, w_out, y_out, x_out};
      out_tuser_r <= vis_c;
      out_tlast_r <= last_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(sgcr_pkg::GLYPH_COLUMNS))
    else $error("cell column past the spacing column");

  a_bar_single: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !head_item.pix_mode && spacing_col) |-> (row_r == '0))
    else $error("scaled spacing bar not on first row");

  a_hidden_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[30:24] == '0 && out_tdata[37:31] == '0))
    else $error("invisible cell with nonzero size");

  a_fresh_start: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> (col_r == '0 && row_r == '0 && xoff_r == '0 && yoff_r == '0))
    else $error("sequencer not rewound after last cell");

endmodule
